// ===== src/pcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Prefix-code bit packer package
// Shared widths, mode codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  // Longest code that the table stores.
  localparam int MAX_CODE_LEN = 32;

  // Field widths of the channels.
  localparam int MODE_W    = 2;
  localparam int SYM_W     = 8;
  localparam int IN_LEN_W  = 6;
  localparam int IN_BITS_W = 32;
  localparam int BYTE_W    = 8;

  // Pending buffer holds up to seven bits.
  localparam int PEND_W = BYTE_W - 1;
  localparam int PCNT_W = 3;

  // Stored code length and the packing accumulator.
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int ACC_W = MAX_CODE_LEN + PEND_W;
  localparam int TOT_W = $clog2(ACC_W + 1);

  localparam int TABLE_DEPTH = 256;

  // Job queue between front and back; depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Mode codes of an input item.
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  // One unit of work for the back end: a code to pack, or a flush.
  typedef struct packed {
    logic                    is_flush;
    logic [LEN_W-1:0]        len;
    logic [MAX_CODE_LEN-1:0] bits;
  } job_t;

endpackage

// ===== src/pcbp_if.sv =====
// ----------------------------------------------------------------------------
// Prefix-code bit packer channels
// Valid/ready interfaces for the input items and the packed output bytes.
// ----------------------------------------------------------------------------
interface pcbp_in_if;
  logic                             valid;
  logic                             ready;
  logic [pcbp_pkg::MODE_W-1:0]      mode;
  logic [pcbp_pkg::SYM_W-1:0]       symbol;
  logic [pcbp_pkg::IN_LEN_W-1:0]    code_length;
  logic [pcbp_pkg::IN_BITS_W-1:0]   code_bits;

  modport source (output valid, output mode, output symbol, output code_length,
                  output code_bits, input ready);
  modport sink   (input valid, input mode, input symbol, input code_length,
                  input code_bits, output ready);
endinterface

interface pcbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [pcbp_pkg::BYTE_W-1:0]   out_byte;
  logic                          last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== src/pcbp_front.sv =====
// ----------------------------------------------------------------------------
// Prefix-code bit packer front end
// Accepts items, keeps the code table and turns encode and flush items into jobs.
// ----------------------------------------------------------------------------
module pcbp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  pcbp_in_if.sink          in_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output pcbp_pkg::job_t   push_job_o
);
  import pcbp_pkg::*;

  logic [LEN_W+MAX_CODE_LEN-1:0] mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]        vld_q;

  logic                          s1_vq;
  logic [MODE_W-1:0]             s1_mode_q;
  logic [LEN_W+MAX_CODE_LEN-1:0] rd_q;
  logic                          hit_q;

  logic                          accept;
  logic                          over;
  logic [IN_LEN_W-1:0]           shamt;
  logic [IN_LEN_W-1:0]           len_n;
  logic [IN_BITS_W-1:0]          bits_s;
  logic [IN_BITS_W-1:0]          bits_m;
  logic [LEN_W-1:0]              rd_len;
  logic [MAX_CODE_LEN-1:0]       rd_bits;
  logic                          need;
  logic                          s1_done;

  assign accept = in_i.valid && in_i.ready;

  // Over-long codes keep their leading bits; bits above the length are dropped.
  always_comb begin
    over   = in_i.code_length > IN_LEN_W'(MAX_CODE_LEN);
    shamt  = in_i.code_length - IN_LEN_W'(MAX_CODE_LEN);
    bits_s = over ? (in_i.code_bits >> shamt) : in_i.code_bits;
    len_n  = over ? IN_LEN_W'(MAX_CODE_LEN) : in_i.code_length;
    bits_m = bits_s & ~({IN_BITS_W{1'b1}} << len_n);
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.mode == MODE_LOAD) begin
      mem[in_i.symbol] <= {len_n[LEN_W-1:0], bits_m[MAX_CODE_LEN-1:0]};
    end
    if (accept) begin
      rd_q <= mem[in_i.symbol];
    end
  end

  assign rd_len  = rd_q[LEN_W+MAX_CODE_LEN-1:MAX_CODE_LEN];
  assign rd_bits = rd_q[MAX_CODE_LEN-1:0];

  always_comb begin
    need = 1'b0;
    case (s1_mode_q)
      MODE_ENCODE: need = hit_q && (rd_len != '0);
      MODE_FLUSH:  need = 1'b1;
      default:     need = 1'b0;
    endcase
  end

  assign push_valid_o        = s1_vq && need;
  assign push_job_o.is_flush = (s1_mode_q == MODE_FLUSH);
  assign push_job_o.len      = (s1_mode_q == MODE_FLUSH) ? '0 : rd_len;
  assign push_job_o.bits     = (s1_mode_q == MODE_FLUSH) ? '0 : rd_bits;

  assign s1_done    = !need || push_ready_i;
  assign in_i.ready = !s1_vq || s1_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      s1_vq     <= 1'b0;
      s1_mode_q <= MODE_LOAD;
      hit_q     <= 1'b0;
    end else begin
      if (accept) begin
        s1_vq     <= 1'b1;
        s1_mode_q <= in_i.mode;
        hit_q     <= vld_q[in_i.symbol];
        if (in_i.mode == MODE_LOAD) begin
          vld_q[in_i.symbol] <= 1'b1;
        end
      end else if (s1_done) begin
        s1_vq <= 1'b0;
      end
    end
  end

endmodule

// ===== src/pcbp_queue.sv =====
// ----------------------------------------------------------------------------
// Prefix-code bit packer job queue
// Short FIFO that decouples the table lookup from the byte packing.
// ----------------------------------------------------------------------------
module pcbp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  pcbp_pkg::job_t   push_job_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output pcbp_pkg::job_t   pop_job_o
);
  import pcbp_pkg::*;

  job_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = q_mem[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/pcbp_back.sv =====
// ----------------------------------------------------------------------------
// Prefix-code bit packer back end
// Merges codes into the pending bits and emits packed bytes one per cycle while the receiver is not stalling.
// ----------------------------------------------------------------------------
module pcbp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  pcbp_pkg::job_t   pop_job_i,
  pcbp_out_if.source       out_o
);
  import pcbp_pkg::*;

  typedef enum logic {ST_IDLE, ST_EMIT} state_e;

  state_e             state_q, state_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [TOT_W-1:0]   tot_q, tot_d;
  logic [PEND_W-1:0]  pb_q, pb_d;
  logic [PCNT_W-1:0]  pc_q, pc_d;
  logic               ov_q, ov_d;
  logic [BYTE_W-1:0]  ob_q, ob_d;
  logic               ol_q, ol_d;

  logic               out_free;
  logic [ACC_W-1:0]   sum_acc;
  logic [TOT_W-1:0]   sum_tot;
  logic [TOT_W-1:0]   rem;
  logic [ACC_W-1:0]   acc_sh;
  logic               elast;
  logic [BYTE_W-1:0]  fbyte;

  assign out_free    = !ov_q || out_o.ready;
  assign pop_ready_o = (state_q == ST_IDLE) && (!pop_job_i.is_flush || out_free);

  always_comb begin
    sum_acc = (ACC_W'(pb_q) << pop_job_i.len) | ACC_W'(pop_job_i.bits);
    sum_tot = TOT_W'(pc_q) + TOT_W'(pop_job_i.len);
    rem     = tot_q - TOT_W'(BYTE_W);
    acc_sh  = acc_q >> rem;
    elast   = rem < TOT_W'(BYTE_W);
    fbyte   = {pb_q, 1'b0} << (PCNT_W'(PEND_W) - pc_q);
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    tot_d   = tot_q;
    pb_d    = pb_q;
    pc_d    = pc_q;
    ov_d    = ov_q && !out_o.ready;
    ob_d    = ob_q;
    ol_d    = ol_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i && pop_ready_o) begin
          if (pop_job_i.is_flush) begin
            // Pad the pending bits with zeros on the right.
            if (pc_q != '0) begin
              ov_d = 1'b1;
              ob_d = fbyte;
              ol_d = 1'b1;
            end
            pb_d = '0;
            pc_d = '0;
          end else if (sum_tot < TOT_W'(BYTE_W)) begin
            pb_d = sum_acc[PEND_W-1:0];
            pc_d = sum_tot[PCNT_W-1:0];
          end else begin
            acc_d   = sum_acc;
            tot_d   = sum_tot;
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d  = 1'b1;
          ob_d  = acc_sh[BYTE_W-1:0];
          ol_d  = elast;
          tot_d = rem;
          if (elast) begin
            pb_d    = acc_q[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
            pc_d    = rem[PCNT_W-1:0];
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
      tot_q   <= '0;
      pb_q    <= '0;
      pc_q    <= '0;
      ov_q    <= 1'b0;
      ob_q    <= '0;
      ol_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      tot_q   <= tot_d;
      pb_q    <= pb_d;
      pc_q    <= pc_d;
      ov_q    <= ov_d;
      ob_q    <= ob_d;
      ol_q    <= ol_d;
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.out_byte = ob_q;
  assign out_o.last     = ol_q;

endmodule

// ===== src/prefix_code_bit_packer.sv =====
// ----------------------------------------------------------------------------
// Prefix-code bit packer
// Table-driven prefix-code encoder that packs codes into a byte stream.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_i (valid/ready). A load item writes one entry of
// the 256-entry code table, an encode item appends its symbol's code to the
// bit stream, and a flush item pads the last partial byte with zeros and
// emits it. Packed bytes leave on out_o (valid/ready), earliest bit in bit 7,
// with last set on the final byte that an item produces.
// An encode item's first byte passes the lookup register, the job queue, the
// packing accumulator and the output register; a flush item's byte skips the
// accumulator. The front end takes one item per cycle as long as the job queue
// has room. The packer merges a code into the pending bits and then emits its
// bytes in turn while the receiver does not stall, up to four per encode item,
// as the output port's byte width sets; it takes no new job while it emits.
// Load items and codeless symbols pass only the front end and make no job.
// Reset clears the table valid bits at once, so every symbol starts without
// a code, and empties the pending buffer, the queue and the output register.
// When the receiver stalls, the output byte holds; the packer waits, the
// queue fills and in_i.ready drops.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcbp_in_if.sink     in_i,
  pcbp_out_if.source  out_o
);
  import pcbp_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  // Front end: table writes, lookups and job classification.
  pcbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // Jobs wait here so that lookups continue while bytes drain.
  pcbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // Back end: bit packing and the output register.
  pcbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // A load item never turns into a job.
  a_load_no_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.mode == MODE_LOAD) |=> !push_valid)
    else $error("load item produced a job");

  // A flush item always turns into a job in the next cycle.
  a_flush_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.mode == MODE_FLUSH) |=> push_valid)
    else $error("flush item produced no job");

  // Every encode job carries a nonzero code length.
  a_encode_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready && !pop_job.is_flush) |-> (pop_job.len != '0))
    else $error("encode job with zero length");
`endif

endmodule

// ===== tb/sv/prefix_code_bit_packer_tb.sv =====
// ----------------------------------------------------------------------------
// Prefix-code bit packer testbench
// Drives load, encode, flush and unused-mode items into the packer with
// random gaps on both channels. A scoreboard keeps its own copy of the code
// table and the pending bit buffer, works out the packed bytes that every
// accepted item must produce, and checks each output byte in order.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_tb;
  import pcbp_pkg::*;

  // The one mode value that the block has no use for.
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  localparam int  RANDOM_ITEMS = 420;
  localparam int  IDLE_PCT     = 12;
  // Window of accepted items during which neither side idles.
  localparam int  CALM_FIRST   = 200;
  localparam int  CALM_LAST    = 300;
  // Cycles to wait after the last expected byte for stray output.
  localparam int  DRAIN_CYCLES = 40;
  localparam longint TIMEOUT   = 2_000_000;

  typedef struct {
    logic [MODE_W-1:0]    mode;
    logic [SYM_W-1:0]     symbol;
    logic [IN_LEN_W-1:0]  code_length;
    logic [IN_BITS_W-1:0] code_bits;
  } code_item_t;

  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } packed_byte_t;

  logic clk_i;
  logic rst_ni;

  pcbp_in_if  in_if ();
  pcbp_out_if out_if ();

  prefix_code_bit_packer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Items still to be offered, and bytes that the packer owes us.
  code_item_t   pending_items_q[$];
  packed_byte_t packed_q[$];

  // Scoreboard copy of the packer state.
  logic [LEN_W-1:0]        code_len_mem [TABLE_DEPTH];
  logic [MAX_CODE_LEN-1:0] code_val_mem [TABLE_DEPTH];
  logic [PEND_W-1:0]       pend_bits;
  logic [PCNT_W-1:0]       pend_cnt;

  logic in_taken;
  int   items_accepted;
  int   n_load, n_encode, n_flush, n_ignored;
  int   bytes_checked;
  int   fails;

  function automatic logic [63:0] low_mask(int unsigned n);
    return (64'd1 << n) - 64'd1;
  endfunction

  // Updates the table and the buffer for one accepted item and queues the
  // bytes that it completes, the final one flagged as last.
  task automatic pack_item(input code_item_t it);
    int unsigned  len;
    int unsigned  total;
    logic [63:0]  bits;
    logic [63:0]  acc;
    packed_byte_t pb;
    case (it.mode)
      MODE_LOAD: begin
        len  = it.code_length;
        bits = 64'(it.code_bits);
        // An over-long code keeps its leading bits.
        if (len > MAX_CODE_LEN) begin
          bits = bits >> (len - MAX_CODE_LEN);
          len  = MAX_CODE_LEN;
        end
        bits = bits & low_mask(len);
        code_len_mem[it.symbol] = LEN_W'(len);
        code_val_mem[it.symbol] = MAX_CODE_LEN'(bits);
        n_load++;
      end
      MODE_ENCODE: begin
        len = code_len_mem[it.symbol];
        if (len != 0) begin
          acc   = (64'(pend_bits) << len) | 64'(code_val_mem[it.symbol]);
          total = pend_cnt + len;
          while (total >= BYTE_W) begin
            pb.out_byte = BYTE_W'(acc >> (total - BYTE_W));
            pb.last     = (total - BYTE_W) < BYTE_W;
            packed_q.push_back(pb);
            total -= BYTE_W;
          end
          pend_bits = PEND_W'(acc & low_mask(total));
          pend_cnt  = PCNT_W'(total);
        end
        n_encode++;
      end
      MODE_FLUSH: begin
        if (pend_cnt != 0) begin
          pb.out_byte = BYTE_W'(64'(pend_bits) << (BYTE_W - pend_cnt));
          pb.last     = 1'b1;
          packed_q.push_back(pb);
        end
        pend_bits = '0;
        pend_cnt  = '0;
        n_flush++;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic add_item(input logic [MODE_W-1:0] mode, input int sym, input int len,
                          input logic [IN_BITS_W-1:0] bits);
    code_item_t it;
    it.mode        = mode;
    it.symbol      = SYM_W'(sym);
    it.code_length = IN_LEN_W'(len);
    it.code_bits   = bits;
    pending_items_q.push_back(it);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT);
    $display("CHECK FAILED");
    $finish;
  end

  // Scoreboard side: inputs are taken and outputs checked at the rising edge.
  always @(posedge clk_i) begin : scoreboard
    code_item_t   got;
    packed_byte_t want;
    if (rst_ni) begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        got.mode        = in_if.mode;
        got.symbol      = in_if.symbol;
        got.code_length = in_if.code_length;
        got.code_bits   = in_if.code_bits;
        pack_item(got);
        items_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (packed_q.size() == 0) begin
          $error("unexpected output byte %02h last %0b", out_if.out_byte, out_if.last);
          fails++;
        end else begin
          want = packed_q.pop_front();
          bytes_checked++;
          if (out_if.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_if.out_byte);
            fails++;
          end
          if (out_if.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_if.last);
            fails++;
          end
        end
      end
    end
  end

  // Driver side: everything changes at the falling edge. An item stays on the
  // channel until the edge that accepts it, then the next one may follow.
  always @(negedge clk_i) begin : driver
    logic       calm;
    logic       go;
    code_item_t nxt;
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      calm = items_accepted >= CALM_FIRST && items_accepted < CALM_LAST;
      out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!in_if.valid || in_taken) begin
        go = pending_items_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT);
        if (go) begin
          nxt = pending_items_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.mode        <= nxt.mode;
          in_if.symbol      <= nxt.symbol;
          in_if.code_length <= nxt.code_length;
          in_if.code_bits   <= nxt.code_bits;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int          live_syms[$];
    int          counted;
    int          r;
    int          sym;
    int          len;
    logic [MODE_W-1:0] mode;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_LOAD;
    in_if.symbol      = '0;
    in_if.code_length = '0;
    in_if.code_bits   = '0;
    out_if.ready      = 1'b0;
    in_taken          = 1'b0;
    items_accepted    = 0;
    n_load = 0; n_encode = 0; n_flush = 0; n_ignored = 0;
    bytes_checked = 0;
    fails = 0;
    // The table comes out of reset with every entry codeless.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      code_len_mem[i] = '0;
      code_val_mem[i] = '0;
    end
    pend_bits = '0;
    pend_cnt  = '0;

    // Directed part. Encoding before any load, and flushing an empty buffer,
    // must both stay silent.
    add_item(MODE_ENCODE, 8'h00, 0, '0);
    add_item(MODE_FLUSH, 8'h00, 0, '0);
    // Bits above the length are dropped; full-length code; one-bit code;
    // over-long codes keep their leading bits; a zero-length load.
    add_item(MODE_LOAD, 8'h41, 3, 32'hFFFF_FFF5);
    add_item(MODE_LOAD, 8'hFF, 32, 32'hDEAD_BEEF);
    add_item(MODE_LOAD, 8'h00, 1, 32'h0000_0001);
    add_item(MODE_LOAD, 8'h80, 45, 32'hA5A5_A5A5);
    add_item(MODE_LOAD, 8'h7F, 63, 32'hFFFF_FFFF);
    add_item(MODE_LOAD, 8'h10, 0, 32'h1234_5678);
    add_item(MODE_ENCODE, 8'h41, 0, '0);
    add_item(MODE_ENCODE, 8'hFF, 0, '0);
    add_item(MODE_ENCODE, 8'h00, 0, '0);
    add_item(MODE_ENCODE, 8'h10, 0, '0);
    add_item(MODE_FLUSH, 8'h00, 0, '0);
    add_item(MODE_IGNORED, 8'hFF, 63, 32'hFFFF_FFFF);
    // A 32-bit code into an empty buffer lands on a byte boundary.
    add_item(MODE_ENCODE, 8'h80, 0, '0);
    add_item(MODE_FLUSH, 8'h00, 0, '0);
    // Seven pending bits plus a 32-bit code is the widest merge.
    add_item(MODE_LOAD, 8'h01, 7, 32'h0000_007F);
    add_item(MODE_ENCODE, 8'h01, 0, '0);
    add_item(MODE_ENCODE, 8'hFF, 0, '0);
    add_item(MODE_FLUSH, 8'h00, 0, '0);
    add_item(MODE_ENCODE, 8'h7F, 0, '0);
    // Overwriting an entry that was already in use.
    add_item(MODE_LOAD, 8'h41, 8, 32'h0000_00C3);
    add_item(MODE_ENCODE, 8'h41, 0, '0);
    add_item(MODE_ENCODE, 8'h7F, 0, '0);
    add_item(MODE_FLUSH, 8'h00, 0, '0);
    live_syms = '{8'h41, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01};

    // Random part. Most items encode symbols that hold a code, so the stream
    // keeps packing; loads rewrite the table on the fly, and flushes and the
    // unused mode break the stream now and then.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 18) mode = MODE_LOAD;
      else if (r < 90) mode = MODE_ENCODE;
      else if (r < 97) mode = MODE_FLUSH;
      else mode = MODE_IGNORED;

      if (mode == MODE_ENCODE && $urandom_range(99) < 85)
        sym = live_syms[$urandom_range(live_syms.size() - 1)];
      else
        sym = $urandom_range(TABLE_DEPTH - 1);

      // Mostly short codes, some long ones, a few over-long or empty.
      r = $urandom_range(99);
      if (r < 5) len = 0;
      else if (r < 60) len = $urandom_range(8, 1);
      else if (r < 85) len = $urandom_range(24, 9);
      else if (r < 95) len = $urandom_range(MAX_CODE_LEN, 25);
      else len = $urandom_range(63, MAX_CODE_LEN + 1);

      if (mode == MODE_LOAD) live_syms.push_back(sym);
      add_item(mode, sym, len, $urandom());
      if (mode != MODE_IGNORED) counted++;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items_q.size() != 0 || in_if.valid || packed_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (packed_q.size() != 0) begin
      $error("%0d expected bytes never arrived", packed_q.size());
      fails += packed_q.size();
    end

    $display("Run covered %0d items: %0d loads, %0d encodes, %0d flushes, %0d ignored.",
             items_accepted, n_load, n_encode, n_flush, n_ignored);
    $display("Checked %0d packed bytes; %0d mismatches.", bytes_checked, fails);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
